[design/hpe_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the Horner polynomial evaluator.
// Used by hpe_serial_mac and horner_polynomial_eval; depends on nothing.

package hpe_pkg;

    localparam int unsigned MAX_DEGREE_DEF = 15;
    localparam int unsigned DATA_W         = 32;
    localparam int unsigned FRAC_BITS      = 16;
    localparam int unsigned DIGIT_W        = 4;
    localparam int unsigned NUM_DIGITS     = DATA_W / DIGIT_W;
    localparam int unsigned DEG_W          = 4;
    localparam int unsigned PADDR_W        = 3;

    // register index, taken from paddr[2]
    localparam logic REG_DEGREE = 1'b0;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD
    } hpe_state_t;

    typedef struct packed {
        logic done;
        logic sat;
    } hpe_mac_stat_t;

endpackage

[design/hpe_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module hpe_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/hpe_serial_mac.sv]
`timescale 1ns / 1ps
// Digit-serial multiply unit followed by floor shift, coefficient add and saturation.
// Depends on hpe_pkg.

module hpe_serial_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [hpe_pkg::DATA_W-1:0]   mcand,
    input  logic signed [hpe_pkg::DATA_W-1:0]   mplier,
    input  logic signed [hpe_pkg::DATA_W-1:0]   coef,
    output logic signed [hpe_pkg::DATA_W-1:0]   result,
    output hpe_pkg::hpe_mac_stat_t              stat
);

    localparam int unsigned DW    = hpe_pkg::DATA_W;
    localparam int unsigned DGW   = hpe_pkg::DIGIT_W;
    localparam int unsigned ND    = hpe_pkg::NUM_DIGITS;
    localparam int unsigned CNT_W = (ND > 1) ? $clog2(ND) : 1;
    localparam int unsigned HI_W  = DW + DGW + 1;
    localparam int unsigned FB    = hpe_pkg::FRAC_BITS;
    // product after the floor shift: 2*DW-FB bits, sign included
    localparam int unsigned SH_W  = DW + DW - FB;
    localparam int unsigned SUM_W = SH_W + 1;

    logic signed [DW-1:0]    mcand_reg;
    logic [DW-1:0]           mplier_reg;
    logic signed [HI_W-1:0]  hi_reg;
    logic [DW-1:0]           lo_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;

    logic                    last;
    logic signed [DGW:0]     dig;
    logic signed [HI_W-1:0]  pp;
    logic signed [HI_W:0]    t;
    logic signed [SH_W-1:0]  shifted;
    logic signed [SUM_W-1:0] sum;

    assign last = (cnt_reg == CNT_W'(ND - 1));

    always_comb
    begin
        // top digit carries the sign weight of the multiplier
        if (last)
        begin
            dig = {mplier_reg[DGW-1], mplier_reg[DGW-1:0]};
        end
        else
        begin
            dig = {1'b0, mplier_reg[DGW-1:0]};
        end
        pp = HI_W'(mcand_reg) * HI_W'(dig);
        t  = (HI_W + 1)'(hi_reg) + (HI_W + 1)'(pp);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            busy_reg <= !last;
            done_reg <= last;
            cnt_reg  <= cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= mcand;
            mplier_reg <= mplier;
            hi_reg     <= '0;
            lo_reg     <= '0;
        end
        else if (busy_reg)
        begin
            mplier_reg <= mplier_reg >> DGW;
            hi_reg     <= HI_W'(t >>> DGW);
            lo_reg     <= {t[DGW-1:0], lo_reg[DW-1:DGW]};
        end
    end

    always_comb
    begin
        shifted = {hi_reg[DW-1:0], lo_reg[DW-1:FB]};
        sum     = SUM_W'(shifted) + SUM_W'(coef);
        stat.done = done_reg;
        if (sum > SUM_W'(signed'({1'b0, {(DW-1){1'b1}}})))
        begin
            result   = {1'b0, {(DW-1){1'b1}}};
            stat.sat = 1'b1;
        end
        else if (sum < SUM_W'(signed'({1'b1, {(DW-1){1'b0}}})))
        begin
            result   = {1'b1, {(DW-1){1'b0}}};
            stat.sat = 1'b1;
        end
        else
        begin
            result   = sum[DW-1:0];
            stat.sat = 1'b0;
        end
    end

endmodule

[design/horner_polynomial_eval.sv]
`timescale 1ns / 1ps
// Horner polynomial evaluator top level: item channels, degree register, coefficient store.
// Depends on hpe_pkg, hpe_ram and hpe_serial_mac.

// A load item writes one coefficient. An evaluate item runs d+1 Horner steps, d
// being the degree clamped to MAX_DEGREE: each step runs the accumulator through a
// 4-bit-per-cycle serial multiplier, hands over to the add/saturate stage and adds
// the coefficient. Only one item is worked on at a time; a finished result sits in
// the output register while further loads are accepted, and a later evaluate waits
// on its last step until that register is free. Coefficients read as zero until
// loaded.

module horner_polynomial_eval #(
    parameter int unsigned MAX_DEGREE = hpe_pkg::MAX_DEGREE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               action,
    input  logic [hpe_pkg::DEG_W-1:0]          coef_index,
    input  logic signed [hpe_pkg::DATA_W-1:0]  coef_value,
    input  logic signed [hpe_pkg::DATA_W-1:0]  point,

    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [hpe_pkg::DATA_W-1:0]  poly_value,
    output logic                               saturated,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [hpe_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int unsigned DEPTH = MAX_DEGREE + 1;
    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned DW    = hpe_pkg::DATA_W;
    localparam int unsigned DGW   = hpe_pkg::DEG_W;

    hpe_pkg::hpe_state_t    state_reg, state_next;
    logic [DGW-1:0]         degree_reg;
    logic [IDX_W-1:0]       k_reg;
    logic signed [DW-1:0]   x_reg;
    logic                   sat_reg;
    logic [DEPTH-1:0]       vld_reg;
    logic                   rd_vld_reg;
    logic                   out_valid_reg;
    logic signed [DW-1:0]   poly_value_reg;
    logic                   saturated_reg;

    logic [IDX_W-1:0]       top_idx;
    logic                   in_fire;
    logic                   eval_fire;
    logic                   load_fire;
    logic                   load_ok;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   mac_start;
    logic signed [DW-1:0]   mac_a;
    logic signed [DW-1:0]   mac_x;
    logic signed [DW-1:0]   coef;
    logic [DW-1:0]          ram_rdata;
    logic signed [DW-1:0]   mac_result;
    hpe_pkg::hpe_mac_stat_t mac_stat;
    logic                   step_go;
    logic                   finish;
    logic                   cfg_wr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        if (paddr[2] == hpe_pkg::REG_DEGREE)
        begin
            prdata = 32'(degree_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= '0;
        end
        else if (cfg_wr && (paddr[2] == hpe_pkg::REG_DEGREE))
        begin
            degree_reg <= pwdata[DGW-1:0];
        end
    end

    always_comb
    begin
        if (32'(degree_reg) > 32'(MAX_DEGREE))
        begin
            top_idx = IDX_W'(MAX_DEGREE);
        end
        else
        begin
            top_idx = IDX_W'(degree_reg);
        end
    end

    assign in_fire   = in_valid && in_ready;
    assign eval_fire = in_fire && (action == hpe_pkg::ACT_EVAL);
    assign load_fire = in_fire && (action == hpe_pkg::ACT_LOAD);
    assign load_ok   = load_fire && (32'(coef_index) <= 32'(MAX_DEGREE));
    assign coef      = rd_vld_reg ? signed'(ram_rdata) : '0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hpe_pkg::ST_IDLE:
            begin
                if (eval_fire)
                begin
                    state_next = hpe_pkg::ST_MUL;
                end
            end
            hpe_pkg::ST_MUL:
            begin
                if (mac_stat.done)
                begin
                    state_next = hpe_pkg::ST_ADD;
                end
            end
            hpe_pkg::ST_ADD:
            begin
                if (step_go)
                begin
                    state_next = hpe_pkg::ST_MUL;
                end
                else if (finish)
                begin
                    state_next = hpe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hpe_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready  = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = top_idx;
        mac_start = 1'b0;
        mac_a     = mac_result;
        mac_x     = x_reg;
        step_go   = 1'b0;
        finish    = 1'b0;
        case (state_reg)
            hpe_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                rd_en     = eval_fire;
                mac_start = eval_fire;
                mac_a     = '0;
                mac_x     = point;
            end
            hpe_pkg::ST_ADD:
            begin
                if (k_reg != '0)
                begin
                    step_go   = 1'b1;
                    rd_en     = 1'b1;
                    rd_addr   = k_reg - IDX_W'(1);
                    mac_start = 1'b1;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    finish = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hpe_pkg::ST_IDLE;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_ok)
            begin
                vld_reg[IDX_W'(coef_index)] <= 1'b1;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_vld_reg <= vld_reg[rd_addr];
        end
        if (eval_fire)
        begin
            x_reg   <= point;
            k_reg   <= top_idx;
            sat_reg <= 1'b0;
        end
        else if (step_go || finish)
        begin
            sat_reg <= sat_reg | mac_stat.sat;
            if (step_go)
            begin
                k_reg <= k_reg - IDX_W'(1);
            end
        end
        if (finish)
        begin
            poly_value_reg <= mac_result;
            saturated_reg  <= sat_reg | mac_stat.sat;
        end
    end

    assign out_valid  = out_valid_reg;
    assign poly_value = poly_value_reg;
    assign saturated  = saturated_reg;

    hpe_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (load_ok),
        .waddr (IDX_W'(coef_index)),
        .wdata (coef_value),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    hpe_serial_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mac_start),
        .mcand  (mac_a),
        .mplier (mac_x),
        .coef   (coef),
        .result (mac_result),
        .stat   (mac_stat)
    );

`ifndef ASSERT_OFF
    // the add stage is only reached once the serial product is complete
    a_add_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hpe_pkg::ST_ADD) |-> mac_stat.done)
        else $error("add stage entered before product complete");

    // an evaluate starts at the clamped top coefficient
    a_eval_start: assert property (@(posedge clk) disable iff (!rst_n)
        eval_fire |=> (state_reg == hpe_pkg::ST_MUL) && (k_reg == $past(top_idx)))
        else $error("evaluate did not start at top coefficient");

    // each step moves one coefficient down
    a_step_down: assert property (@(posedge clk) disable iff (!rst_n)
        step_go |=> (k_reg == $past(k_reg) - IDX_W'(1)))
        else $error("step index did not decrement");

    // a result is only written when the output register is free or being drained
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> (!out_valid_reg || out_ready))
        else $error("result overwritten while waiting");
`endif

endmodule
